// ===== src/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Package of the JSON string unescape block: modes, result kinds, word and
// command types, character codes and the UTF-8 encoder. No dependencies.
package jsu_pkg;

    localparam int RES_MAX = 5;
    localparam int QDEPTH  = 4;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WS,
        MODE_STR,
        MODE_ESC,
        MODE_HEX1,
        MODE_HIGH,
        MODE_HIGH_BS,
        MODE_HEX2,
        MODE_DONE,
        MODE_ERR
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [15:0] HIGH_LO = 16'hD800;
    localparam logic [15:0] HIGH_HI = 16'hDBFF;
    localparam logic [15:0] LOW_LO  = 16'hDC00;
    localparam logic [15:0] LOW_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        logic [2:0]               cnt;
        t_res [RES_MAX-1:0]       res;
    } t_cmd;

    typedef struct packed {
        logic [2:0]       cnt;
        logic [3:0][7:0]  b;
    } t_utf8;

    function automatic t_utf8 f_utf8(input logic [20:0] cp);
        t_utf8 e;
        e = '0;
        if (cp < 21'h80) begin
            e.cnt  = 3'd1;
            e.b[0] = {1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            e.cnt  = 3'd2;
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            e.cnt  = 3'd3;
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
        end else begin
            e.cnt  = 3'd4;
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== src/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// Top level of the JSON string unescape block: front end, command queue,
// back end. Uses jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
// Usage:
//   s_axis: one raw text byte per word. tdata[7:0] = byte, tuser[0] = begin
//   of a new literal, tlast = no byte follows in the buffer.
//   m_axis: one decoded word per handshake. tdata[7:0] = UTF-8 byte (0 for
//   close/error), tuser[1:0] = kind (0 data, 1 closing quote, 2 error),
//   tlast = final word caused by that input byte.
//   Accepted words' results are queued. Throughput while the receiver is
//   ready: one input word per cycle while each yields at most one result;
//   a word yielding n results holds the back end for n output words, one
//   per cycle, and a 4-command queue absorbs the bursts. Input bytes
//   giving no result do not enter the queue.
//   Reset (synchronous, active low) empties the queue and puts the decoder
//   idle; bytes are ignored until one arrives with begin set.
//   When the receiver stalls the queue fills; s_axis_tready drops only with
//   four commands waiting, and nothing is lost.
module json_string_unescape_utf8 import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,   // [0] begin_req
    input  logic       s_axis_tlast,   // end_of_data
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // last
);

    logic push, full, q_valid, pop;
    t_cmd cmd, head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_begin (s_axis_tuser[0]),
        .i_eod   (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== src/jsu_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input words, runs the literal/escape/hex state machine
// and pushes a word's results (up to five) as one command. Uses jsu_pkg.
module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_begin,
    input  logic       i_eod,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef struct packed {
        logic       v;
        t_kind      kind;
        logic [7:0] data;
        t_mode      mode;
    } t_step;

    function automatic t_step f_str(input logic [7:0] c);
        t_step s;
        s = '{v: 1'b1, kind: KIND_DATA, data: c, mode: MODE_STR};
        if (c == CH_QUOTE) begin
            s.kind = KIND_CLOSE;
            s.data = '0;
            s.mode = MODE_DONE;
        end else if (c == CH_BSLASH) begin
            s.v    = 1'b0;
            s.mode = MODE_ESC;
        end
        return s;
    endfunction

    function automatic t_step f_esc(input logic [7:0] c);
        t_step s;
        s = '{v: 1'b1, kind: KIND_DATA, data: c, mode: MODE_STR};
        if      (c == CH_LC_B) s.data = CH_BS;
        else if (c == CH_LC_F) s.data = CH_FF;
        else if (c == CH_LC_N) s.data = CH_LF;
        else if (c == CH_LC_R) s.data = CH_CR;
        else if (c == CH_LC_T) s.data = CH_TAB;
        else if (c == CH_LC_U) begin
            s.v    = 1'b0;
            s.mode = MODE_HEX1;
        end
        return s;
    endfunction

    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39)      h = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            h = {1'b1, c[3:0] + 4'd9};
        return h;
    endfunction

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex_value, n_hex_value;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_pending_high, n_pending_high;

    logic        accept;
    logic        pre_v, cpb_v, err;
    logic [20:0] cpb;
    logic [4:0]  hd;
    logic [15:0] hv_new;
    t_step       st;
    t_utf8       ea, eb;
    t_cmd        cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_mode         = r_mode;
        n_hex_value    = r_hex_value;
        n_hex_count    = r_hex_count;
        n_pending_high = r_pending_high;
        if (i_begin) begin
            n_mode         = MODE_WS;
            n_hex_value    = '0;
            n_hex_count    = '0;
            n_pending_high = '0;
        end
        pre_v  = 1'b0;
        cpb_v  = 1'b0;
        cpb    = '0;
        err    = 1'b0;
        st     = '{v: 1'b0, kind: KIND_DATA, data: 8'h00, mode: MODE_STR};
        hd     = f_hex(i_data);
        hv_new = {n_hex_value[11:0], hd[3:0]};

        unique case (n_mode)
            MODE_WS: begin
                if (i_data == CH_QUOTE) begin
                    n_mode = MODE_STR;
                end else if (!(i_data == CH_SPACE || i_data == CH_TAB ||
                               i_data == CH_LF || i_data == CH_CR)) begin
                    err    = 1'b1;
                    n_mode = MODE_ERR;
                end
            end
            MODE_STR: begin
                st     = f_str(i_data);
                n_mode = st.mode;
            end
            MODE_ESC: begin
                st     = f_esc(i_data);
                n_mode = st.mode;
                if (st.mode == MODE_HEX1) begin
                    n_hex_value = '0;
                    n_hex_count = '0;
                end
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hd[4]) begin
                    err    = 1'b1;
                    n_mode = MODE_ERR;
                end else begin
                    n_hex_value = hv_new;
                    if (n_hex_count != 2'd3) begin
                        n_hex_count = n_hex_count + 2'd1;
                    end else begin
                        n_hex_count = '0;
                        if (n_mode == MODE_HEX1) begin
                            if (hv_new >= HIGH_LO && hv_new <= HIGH_HI) begin
                                n_pending_high = hv_new;
                                n_mode         = MODE_HIGH;
                            end else begin
                                cpb_v  = 1'b1;
                                cpb    = {5'b0, hv_new};
                                n_mode = MODE_STR;
                            end
                        end else begin
                            cpb_v  = 1'b1;
                            n_mode = MODE_STR;
                            if (hv_new >= LOW_LO && hv_new <= LOW_HI)
                                cpb = SUPP_BASE + {1'b0, n_pending_high[9:0], hv_new[9:0]};
                            else
                                cpb = {5'b0, n_pending_high};
                        end
                    end
                end
            end
            MODE_HIGH: begin
                if (i_data == CH_BSLASH) begin
                    n_mode = MODE_HIGH_BS;
                end else begin
                    pre_v  = 1'b1;
                    st     = f_str(i_data);
                    n_mode = st.mode;
                end
            end
            MODE_HIGH_BS: begin
                if (i_data == CH_LC_U) begin
                    n_mode      = MODE_HEX2;
                    n_hex_value = '0;
                    n_hex_count = '0;
                end else begin
                    pre_v  = 1'b1;
                    st     = f_esc(i_data);
                    n_mode = st.mode;
                    if (st.mode == MODE_HEX1) begin
                        n_hex_value = '0;
                        n_hex_count = '0;
                    end
                end
            end
            default: ;
        endcase

        // early end of data
        if (i_eod && n_mode != MODE_IDLE && n_mode != MODE_DONE && n_mode != MODE_ERR) begin
            if (n_mode == MODE_HIGH || n_mode == MODE_HIGH_BS)
                pre_v = 1'b1;
            err    = 1'b1;
            n_mode = MODE_ERR;
        end

        // assemble result words in order
        ea  = pre_v ? f_utf8({5'b0, n_pending_high}) : '0;
        eb  = cpb_v ? f_utf8(cpb) : '0;
        cmd = '0;
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < ea.cnt && cmd.cnt < 3'(RES_MAX)) begin
                cmd.res[cmd.cnt] = '{kind: KIND_DATA, data: ea.b[k]};
                cmd.cnt          = cmd.cnt + 3'd1;
            end
        end
        if (st.v && cmd.cnt < 3'(RES_MAX)) begin
            cmd.res[cmd.cnt] = '{kind: st.kind, data: st.data};
            cmd.cnt          = cmd.cnt + 3'd1;
        end
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < eb.cnt && cmd.cnt < 3'(RES_MAX)) begin
                cmd.res[cmd.cnt] = '{kind: KIND_DATA, data: eb.b[k]};
                cmd.cnt          = cmd.cnt + 3'd1;
            end
        end
        if (err && cmd.cnt < 3'(RES_MAX)) begin
            cmd.res[cmd.cnt] = '{kind: KIND_ERROR, data: 8'h00};
            cmd.cnt          = cmd.cnt + 3'd1;
        end
    end

    assign o_push = accept && (cmd.cnt != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_hex_value    <= '0;
            r_hex_count    <= '0;
            r_pending_high <= '0;
        end else if (accept) begin
            r_mode         <= n_mode;
            r_hex_value    <= n_hex_value;
            r_hex_count    <= n_hex_count;
            r_pending_high <= n_pending_high;
        end
    end

endmodule

// ===== src/jsu_queue.sv =====
`timescale 1ns / 1ps
// Command queue between front and back end, QDEPTH entries of t_cmd.
// Uses jsu_pkg.
module jsu_queue import jsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    localparam int PW = $clog2(QDEPTH);

    t_cmd          r_mem [QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + PW'(1);
            if (i_pop)
                r_rd <= r_rd + PW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + (PW+1)'(1);
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - (PW+1)'(1);
        end
    end

endmodule

// ===== src/jsu_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the head command's result words onto the output stream, one
// word per cycle unless stalled; pops the command after its last word. Uses jsu_pkg.
module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic [1:0] o_tuser,
    output logic       o_tlast
);

    logic [2:0] r_idx;
    t_res       cur;

    assign cur      = i_head.res[r_idx];
    assign o_tvalid = i_valid;
    assign o_tdata  = cur.data;
    assign o_tuser  = cur.kind;
    assign o_tlast  = (r_idx == i_head.cnt - 3'd1);
    assign o_pop    = i_valid && i_tready && o_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_valid && i_tready) begin
            r_idx <= o_tlast ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

// ===== src/jsu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for json_string_unescape_utf8 and its bind statement.
// Uses jsu_pkg.
module jsu_checker import jsu_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [0:0] s_axis_tuser,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("m_axis payload changed while stalled");

    // close and error always end the words of their input byte
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tlast)
        else $error("close/error word not marked last");

    a_status_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata == 8'h00)
        else $error("close/error word with nonzero data");

endmodule

bind json_string_unescape_utf8 jsu_checker u_chk (.*);

// ===== dv/tb_json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// Testbench of json_string_unescape_utf8: JSON string literals in, decoded UTF-8 words out,
// checked word by word against a decoder model kept in a scoreboard class. Uses jsu_pkg.
module tb_json_string_unescape_utf8 import jsu_pkg::*; ();

    localparam int CLK_PERIOD   = 4;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NO_EOD       = -1;
    localparam int EOD_LAST     = -2;
    localparam int PHASE_BYTES  = 110;

    typedef struct packed {
        logic       last;
        t_kind      kind;
        logic [7:0] data;
    } t_out_word;

    class utf8_scoreboard;
        t_mode       mode;
        logic [15:0] hex_acc;
        logic [1:0]  hex_n;
        logic [15:0] high_half;
        t_out_word   expected[$];
        t_out_word   step_words[$];
        int          errors;
        int          words_seen;

        function new();
            mode       = MODE_IDLE;
            hex_acc    = '0;
            hex_n      = '0;
            high_half  = '0;
            errors     = 0;
            words_seen = 0;
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - 8'h30);
            if (c >= "a" && c <= "f") return int'(c - 8'h57);
            if (c >= "A" && c <= "F") return int'(c - 8'h37);
            return -1;
        endfunction

        function void emit(t_kind k, logic [7:0] b);
            t_out_word w;
            w.kind = k;
            w.data = (k == KIND_DATA) ? b : 8'h00;
            w.last = 1'b0;
            step_words = {step_words, w};
        endfunction

        function void emit_cp(logic [20:0] cp);
            if (cp < 21'h80) begin
                emit(KIND_DATA, cp[7:0]);
            end else if (cp < 21'h800) begin
                emit(KIND_DATA, 8'hC0 | cp[10:6]);
                emit(KIND_DATA, 8'h80 | cp[5:0]);
            end else if (cp < 21'h10000) begin
                emit(KIND_DATA, 8'hE0 | cp[15:12]);
                emit(KIND_DATA, 8'h80 | cp[11:6]);
                emit(KIND_DATA, 8'h80 | cp[5:0]);
            end else begin
                emit(KIND_DATA, 8'hF0 | cp[20:18]);
                emit(KIND_DATA, 8'h80 | cp[17:12]);
                emit(KIND_DATA, 8'h80 | cp[11:6]);
                emit(KIND_DATA, 8'h80 | cp[5:0]);
            end
        endfunction

        function void halt();
            emit(KIND_ERROR, 8'h00);
            mode = MODE_ERR;
        endfunction

        function void string_char(logic [7:0] c);
            if (c == CH_QUOTE) begin
                emit(KIND_CLOSE, 8'h00);
                mode = MODE_DONE;
            end else if (c == CH_BSLASH) begin
                mode = MODE_ESC;
            end else begin
                emit(KIND_DATA, c);
            end
        endfunction

        function void escape_char(logic [7:0] c);
            logic [7:0] v;
            v    = c;
            mode = MODE_STR;
            case (c)
                CH_LC_B: v = CH_BS;
                CH_LC_F: v = CH_FF;
                CH_LC_N: v = CH_LF;
                CH_LC_R: v = CH_CR;
                CH_LC_T: v = CH_TAB;
                CH_LC_U: begin
                    mode    = MODE_HEX1;
                    hex_acc = '0;
                    hex_n   = '0;
                    return;
                end
                default: ;
            endcase
            emit(KIND_DATA, v);
        endfunction

        function void hex_digit_in(logic [7:0] c);
            int d;
            d = digit_value(c);
            if (d < 0) begin
                halt();
                return;
            end
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_n != 2'd3) begin
                hex_n++;
                return;
            end
            hex_n = '0;
            if (mode == MODE_HEX1) begin
                if (hex_acc >= HIGH_LO && hex_acc <= HIGH_HI) begin
                    high_half = hex_acc;
                    mode      = MODE_HIGH;
                end else begin
                    emit_cp({5'b0, hex_acc});
                    mode = MODE_STR;
                end
            end else begin
                // second escape: pair only with a low half, else the high half goes out alone
                if (hex_acc >= LOW_LO && hex_acc <= LOW_HI)
                    emit_cp(SUPP_BASE + {1'b0, high_half[9:0], hex_acc[9:0]});
                else
                    emit_cp({5'b0, high_half});
                mode = MODE_STR;
            end
        endfunction

        function void note_input(logic [7:0] c, logic beg, logic eod);
            t_out_word w;
            int        n;
            step_words.delete();
            if (beg) begin
                mode      = MODE_WS;
                hex_acc   = '0;
                hex_n     = '0;
                high_half = '0;
            end
            case (mode)
                MODE_WS: begin
                    if (c == CH_QUOTE)
                        mode = MODE_STR;
                    else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR))
                        halt();
                end
                MODE_STR: string_char(c);
                MODE_ESC: escape_char(c);
                MODE_HEX1, MODE_HEX2: hex_digit_in(c);
                MODE_HIGH: begin
                    if (c == CH_BSLASH) begin
                        mode = MODE_HIGH_BS;
                    end else begin
                        emit_cp({5'b0, high_half});
                        mode = MODE_STR;
                        string_char(c);
                    end
                end
                MODE_HIGH_BS: begin
                    if (c == CH_LC_U) begin
                        mode    = MODE_HEX2;
                        hex_acc = '0;
                        hex_n   = '0;
                    end else begin
                        emit_cp({5'b0, high_half});
                        escape_char(c);
                    end
                end
                default: ;
            endcase
            if (eod && mode != MODE_IDLE && mode != MODE_DONE && mode != MODE_ERR) begin
                if (mode == MODE_HIGH || mode == MODE_HIGH_BS)
                    emit_cp({5'b0, high_half});
                halt();
            end
            n = step_words.size();
            if (n > RES_MAX) n = RES_MAX;
            for (int i = 0; i < n; i++) begin
                w        = step_words[i];
                w.last   = (i == n - 1);
                expected = {expected, w};
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("[%0t] word %0d: %s", $time, words_seen, what);
        endtask

        task check_result(logic [7:0] data, logic [1:0] kind, logic last);
            t_out_word w;
            words_seen++;
            if (expected.size() == 0) begin
                report($sformatf("unexpected word data=%h kind=%0d last=%0b", data, kind, last));
                return;
            end
            w = expected.pop_front();
            if (kind !== w.kind)
                report($sformatf("kind %0d, expected %0d", kind, w.kind));
            if (data !== w.data)
                report($sformatf("data %h, expected %h", data, w.data));
            if (last !== w.last)
                report($sformatf("last %0b, expected %0b", last, w.last));
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic [0:0] s_axis_tuser  = 1'b0;    // [0] begin_req
    logic       s_axis_tlast  = 1'b0;    // end_of_data
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [1:0] m_axis_tuser;            // [1:0] kind
    logic       m_axis_tlast;            // last

    utf8_scoreboard sb;
    int             tx_idle_pct = 19;
    int             rx_idle_pct = 76;
    logic [7:0]     lit_bytes[$];

    json_string_unescape_utf8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[json_string_unescape_utf8] ERROR");
        $finish;
    end

    function automatic logic [7:0] hex_ascii(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(7))
            0: return CH_LC_B;
            1: return CH_LC_F;
            2: return CH_LC_N;
            3: return CH_LC_R;
            4: return CH_LC_T;
            5: return CH_QUOTE;
            6: return CH_BSLASH;
            default: return 8'h2F;
        endcase
    endfunction

    function automatic logic [15:0] rand_high();
        return HIGH_LO + 16'($urandom_range(10'h3FF));
    endfunction

    function automatic logic [15:0] rand_low();
        return LOW_LO + 16'($urandom_range(10'h3FF));
    endfunction

    task automatic send_byte(logic [7:0] b, logic beg, logic eod);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= beg;
        s_axis_tlast  <= eod;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(b, beg, eod);
    endtask

    task automatic send_run(int eod_at);
        int last_idx;
        last_idx = (eod_at == EOD_LAST) ? lit_bytes.size() - 1 : eod_at;
        foreach (lit_bytes[i])
            send_byte(lit_bytes[i], i == 0, i == last_idx);
        lit_bytes.delete();
    endtask

    task automatic send_loose(int n);
        repeat (n) send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    endtask

    task automatic add_byte(logic [7:0] b);
        lit_bytes = {lit_bytes, b};
    endtask

    task automatic load_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_u(logic [15:0] v);
        add_byte(CH_BSLASH);
        add_byte(CH_LC_U);
        add_byte(hex_ascii(v[15:12]));
        add_byte(hex_ascii(v[11:8]));
        add_byte(hex_ascii(v[7:4]));
        add_byte(hex_ascii(v[3:0]));
    endtask

    task automatic random_literal(output int n_sent);
        logic [7:0]  b;
        logic [15:0] cp;
        int          eod_at;
        int          sel;
        repeat ($urandom_range(2)) add_byte(pick_blank());
        if ($urandom_range(19) == 0) begin
            b = 8'($urandom_range(255));
            if (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR)
                b = 8'h78;
            add_byte(b);
        end else begin
            add_byte(CH_QUOTE);
        end
        repeat ($urandom_range(6)) begin
            case ($urandom_range(15))
                0, 1, 2, 3, 4: begin
                    b = 8'($urandom_range(255));
                    if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h41;
                    add_byte(b);
                end
                5, 6: begin
                    add_byte(CH_BSLASH);
                    add_byte(pick_escape());
                end
                7: begin
                    b = 8'($urandom_range(255));
                    if (b == CH_LC_U) b = 8'h2F;
                    add_byte(CH_BSLASH);
                    add_byte(b);
                end
                8, 9: begin
                    case ($urandom_range(2))
                        0: cp = 16'($urandom_range(16'h7F));
                        1: cp = 16'($urandom_range(16'h7FF, 16'h80));
                        default: begin
                            cp = 16'($urandom_range(16'hFFFF, 16'h800));
                            if (cp >= HIGH_LO && cp <= LOW_HI) cp = cp ^ 16'h2000;
                        end
                    endcase
                    add_u(cp);
                end
                10, 11: begin
                    add_u(rand_high());
                    add_u(rand_low());
                end
                12: add_u(rand_high());
                13: add_u(rand_low());
                14: begin
                    cp = 16'($urandom_range(16'hFFFF));
                    if (cp >= LOW_LO && cp <= LOW_HI) cp = cp ^ 16'h4000;
                    add_u(rand_high());
                    add_u(cp);
                end
                default: begin
                    add_byte(CH_BSLASH);
                    add_byte(CH_LC_U);
                    repeat ($urandom_range(3)) add_byte(hex_ascii(4'($urandom_range(15))));
                    do b = 8'($urandom_range(255)); while (sb.digit_value(b) >= 0);
                    add_byte(b);
                end
            endcase
        end
        sel = $urandom_range(19);
        if (sel < 15) begin
            add_byte(CH_QUOTE);
            eod_at = $urandom_range(1) ? EOD_LAST : NO_EOD;
        end else if (sel < 18) begin
            eod_at = EOD_LAST;
        end else if (sel == 18) begin
            eod_at = int'($urandom_range(lit_bytes.size() - 1));
        end else begin
            eod_at = NO_EOD;
        end
        n_sent = lit_bytes.size();
        send_run(eod_at);
    endtask

    task automatic random_phase(int n);
        int sent;
        int got;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) send_loose($urandom_range(3, 1));
            random_literal(got);
            sent += got;
        end
    endtask

    task automatic directed_literals();
        send_loose(2);
        load_text(" \t\n\r\"ab\"");
        send_run(NO_EOD);
        load_text("\"\\b\\f\\n\\r\\t\\\"\\\\\\/\\q\"");
        send_run(NO_EOD);
        load_text("\"\\u0041\\u00e9\\u07FF\\u0800\\u20AC\\uFFFF\\u0000\"");
        send_run(EOD_LAST);
        load_text("\"\\uD83D\\ude00\\uDBFF\\uDFFF\\uD800\\uDC00\"");
        send_run(NO_EOD);
        // lone high before plain byte, escape, non-low escape and quote; lone lows
        load_text("\"\\uD800x\\uDBFF\\n\\uD800\\u0041\\uDC00\\uDFFF\\uD800\"");
        send_run(NO_EOD);
        send_loose(2);
        load_text("\"\\u12G4\"");
        send_run(NO_EOD);
        send_loose(2);
        load_text("  x\"");
        send_run(NO_EOD);
        load_text("\"ab");
        send_run(EOD_LAST);
        load_text("\"\\uD800a");
        send_run(EOD_LAST);
        load_text("\"\\uD83D\\uDE01");
        send_run(EOD_LAST);
        load_text("\"\\uD800\\");
        send_run(EOD_LAST);
        load_text("\"\\u12");
        send_run(EOD_LAST);
        load_text("\"\\");
        send_run(EOD_LAST);
        load_text("\"");
        send_run(EOD_LAST);
        load_text("\"abc");
        send_run(NO_EOD);
        load_text("\"d\"");
        send_run(NO_EOD);
        lit_bytes = '{CH_QUOTE, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_QUOTE};
        send_run(NO_EOD);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_literals();
        random_phase(PHASE_BYTES);
        tx_idle_pct = 76;
        rx_idle_pct = 19;
        random_phase(PHASE_BYTES);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(PHASE_BYTES);

        s_axis_tvalid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[json_string_unescape_utf8] OK");
        else
            $display("[json_string_unescape_utf8] ERROR");
        $finish;
    end

endmodule
